FILE: sv/wmmp_pkg.sv
// Shared constants, types and codes for the windowed mean and median unit.
// Used by wmmp_chan, wmmp_div and the top level; depends on nothing.
package wmmp_pkg;

	// Window geometry and sample format
	localparam int MAX_WINDOW = 16;
	localparam int SAMPLE_W   = 32;
	localparam int IDX_W      = $clog2(MAX_WINDOW);
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int LEN_W      = 5;
	localparam int SUM_W      = SAMPLE_W + IDX_W;
	localparam int DIV_CNT_W  = $clog2(SUM_W);

	// Item kinds carried in the input tuser
	localparam logic FUNC_PUSH  = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	// Reset value of the window length register
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic [CNT_W-1:0]           cnt_t;
	typedef logic [IDX_W-1:0]           idx_t;

	// Sequencer controls for one channel datapath
	typedef struct packed {
		logic load;    // latch the candidate entry and clear its rank counts
		logic scan;    // compare one window entry against the candidate
		logic first;   // first candidate: clear / accumulate the window sum
		logic last_j;  // this scan beat reads the last held entry
	} chan_ctl_t;

endpackage

FILE: sv/wmmp_chan.sv
// One channel datapath: ring window storage, rank counter for the median,
// and the window sum accumulator. Depends on wmmp_pkg.
module wmmp_chan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  wmmp_pkg::idx_t      wr_addr,
	input  wmmp_pkg::sample_t   wr_data,
	input  wmmp_pkg::idx_t      rd_addr,
	input  wmmp_pkg::chan_ctl_t ctl,
	input  wmmp_pkg::cnt_t      mid,
	input  logic                even,
	output wmmp_pkg::sum_t      sum,
	output wmmp_pkg::sample_t   median
);

	wmmp_pkg::sample_t win_q [wmmp_pkg::MAX_WINDOW];
	wmmp_pkg::sample_t rd_data;
	wmmp_pkg::sample_t cand_q;
	wmmp_pkg::sample_t lo_q;
	wmmp_pkg::sample_t hi_q;
	wmmp_pkg::sample_t avg_x;
	wmmp_pkg::sum_t    sum_q;
	wmmp_pkg::cnt_t    less_q;
	wmmp_pkg::cnt_t    le_q;
	wmmp_pkg::cnt_t    less_n;
	wmmp_pkg::cnt_t    le_n;
	wmmp_pkg::cnt_t    mid_p1;
	logic              lt;
	logic              eq;

	// Window storage, one write and one read address per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			win_q[wr_addr] <= wr_data;
		end
	end

	assign rd_data = win_q[rd_addr];

	// Shared comparator: entry against candidate
	assign lt     = rd_data < cand_q;
	assign eq     = rd_data == cand_q;
	assign less_n = less_q + wmmp_pkg::CNT_W'(lt);
	assign le_n   = le_q + wmmp_pkg::CNT_W'(lt | eq);
	assign mid_p1 = wmmp_pkg::CNT_W'(mid + 1'b1);

	// Candidate, rank counts and sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			less_q <= '0;
			le_q   <= '0;
		end else if (ctl.load) begin
			less_q <= '0;
			le_q   <= '0;
		end else if (ctl.scan) begin
			less_q <= less_n;
			le_q   <= le_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cand_q <= rd_data;
			if (ctl.first) begin
				sum_q <= '0;
			end
		end
		if (ctl.scan) begin
			if (ctl.first) begin
				sum_q <= sum_q + {{wmmp_pkg::IDX_W{rd_data[wmmp_pkg::SAMPLE_W-1]}}, rd_data};
			end
			// Candidate owns sorted positions [less, le-1]
			if (ctl.last_j) begin
				if (less_n <= mid && mid < le_n) begin
					lo_q <= cand_q;
				end
				if (less_n <= mid_p1 && mid_p1 < le_n) begin
					hi_q <= cand_q;
				end
			end
		end
	end

	// Floor average of the two middle entries without overflow
	assign avg_x  = lo_q ^ hi_q;
	assign median = even ? (lo_q & hi_q) + (avg_x >>> 1) : lo_q;
	assign sum    = sum_q;

endmodule

FILE: sv/wmmp_div.sv
// Restoring serial divider, one quotient bit per cycle, sum over count,
// truncated toward zero. Depends on wmmp_pkg.
module wmmp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  wmmp_pkg::sum_t    dividend,
	input  wmmp_pkg::cnt_t    divisor,
	output logic              done,
	output wmmp_pkg::sample_t quotient
);

	logic [wmmp_pkg::SUM_W-1:0]     quo_q;
	logic [wmmp_pkg::SUM_W-1:0]     quo_signed;
	logic [wmmp_pkg::CNT_W-1:0]     rem_q;
	logic [wmmp_pkg::CNT_W-1:0]     div_q;
	logic [wmmp_pkg::CNT_W:0]       trial;
	logic [wmmp_pkg::CNT_W:0]       trial_sub;
	logic [wmmp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic                           neg_q;
	logic                           ge;

	// One restoring step
	assign trial     = {rem_q, quo_q[wmmp_pkg::SUM_W-1]};
	assign ge        = trial >= {1'b0, div_q};
	assign trial_sub = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == wmmp_pkg::DIV_CNT_W'(wmmp_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[wmmp_pkg::SUM_W-1];
			quo_q <= dividend[wmmp_pkg::SUM_W-1] ? ~dividend + 1'b1 : dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[wmmp_pkg::CNT_W-1:0] : trial[wmmp_pkg::CNT_W-1:0];
			quo_q <= {quo_q[wmmp_pkg::SUM_W-2:0], ge};
		end
	end

	// Restore the sign; the mean always fits the sample width
	assign quo_signed = neg_q ? ~quo_q + 1'b1 : quo_q;
	assign quotient   = quo_signed[wmmp_pkg::SAMPLE_W-1:0];
	assign done       = done_q;

`ifndef NO_ASSERTIONS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
`endif

endmodule

FILE: sv/windowed_mean_median_pair_unit.sv
// Top level: stream ports, window pointer and count, sequencer, result register.
// Instantiates wmmp_chan (pitch, roll) and wmmp_div; depends on wmmp_pkg.
//
//  port group  dir  payload (low bit up)
//  s_axis      in   tdata: pitch_sample, roll_sample; tuser: func
//  m_axis      out  tdata: mean_pitch, mean_roll, median_pitch, median_roll,
//                   sample_count, pad; tuser: stats_valid
//  cfg         in   data: window_length
//
// An item with n held samples steps through LOAD and SCAN once per candidate, then
// DIVP, DIVR and FIN: the rank scan re-reads the window once per candidate through
// one comparator, and one serial divider forms both means in turn.
// An item that leaves the windows empty goes from LOAD straight to FIN.
// Reset empties the windows and sets the length to 16; no clearing pass.
// Input is taken again while a result waits in the output register.
module windowed_mean_median_pair_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,   // pitch_sample[31:0], roll_sample[63:32]
	input  logic [0:0]   s_axis_tuser,   // func[0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata,   // mean_pitch, mean_roll, median_pitch,
	                                     // median_roll, sample_count[132:128]
	output logic [0:0]   m_axis_tuser,   // stats_valid[0]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [4:0]   cfg_data        // window_length
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOAD = 6'b000010,
		ST_SCAN = 6'b000100,
		ST_DIVP = 6'b001000,
		ST_DIVR = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t                        state_q;
	logic [wmmp_pkg::LEN_W-1:0]    len_q;
	wmmp_pkg::idx_t                wp_q;
	wmmp_pkg::cnt_t                held_q;
	wmmp_pkg::idx_t                cand_q;
	wmmp_pkg::idx_t                j_q;
	wmmp_pkg::sample_t             mean_p_q;
	wmmp_pkg::sample_t             mean_r_q;
	logic                          out_valid_q;
	logic [135:0]                  out_data_q;
	logic                          out_user_q;
	logic                          div_go_q;

	wmmp_pkg::cnt_t                eff_len;
	wmmp_pkg::idx_t                wp_use;
	wmmp_pkg::cnt_t                wp_inc;
	wmmp_pkg::cnt_t                held_m1;
	wmmp_pkg::cnt_t                mid;
	logic                          even;
	logic                          in_acc;
	logic                          push;
	logic                          last_j;
	logic                          last_cand;
	logic                          out_free;
	wmmp_pkg::idx_t                rd_addr;
	wmmp_pkg::chan_ctl_t           ctl;
	wmmp_pkg::sum_t                sum_p;
	wmmp_pkg::sum_t                sum_r;
	wmmp_pkg::sample_t             med_p;
	wmmp_pkg::sample_t             med_r;
	logic                          div_start;
	logic                          div_done;
	wmmp_pkg::sum_t                div_in;
	wmmp_pkg::sample_t             div_q;

	// Handshakes
	assign s_axis_tready = state_q == ST_IDLE;
	assign cfg_ready     = 1'b1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign push          = in_acc && s_axis_tuser[0] == wmmp_pkg::FUNC_PUSH;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Effective length: zero acts as one, above the maximum clamps
	always_comb begin
		if (len_q == '0) begin
			eff_len = wmmp_pkg::CNT_W'(1);
		end else if (32'(len_q) > wmmp_pkg::MAX_WINDOW) begin
			eff_len = wmmp_pkg::CNT_W'(wmmp_pkg::MAX_WINDOW);
		end else begin
			eff_len = wmmp_pkg::CNT_W'(len_q);
		end
	end

	// Ring pointer
	assign wp_use = ({1'b0, wp_q} >= eff_len) ? '0 : wp_q;
	assign wp_inc = wmmp_pkg::CNT_W'({1'b0, wp_use} + 1'b1);

	// Rank and count bookkeeping
	assign held_m1   = held_q - 1'b1;
	assign mid       = held_m1 >> 1;
	assign even      = !held_q[0];
	assign last_j    = {1'b0, j_q} == held_m1;
	assign last_cand = {1'b0, cand_q} == held_m1;

	// Channel controls
	assign rd_addr    = (state_q == ST_LOAD) ? cand_q : j_q;
	assign ctl.load   = state_q == ST_LOAD;
	assign ctl.scan   = state_q == ST_SCAN;
	assign ctl.first  = cand_q == '0;
	assign ctl.last_j = last_j;

	// Divider: pitch sum in the first divide cycle, roll sum after pitch is done
	assign div_start = div_go_q || (state_q == ST_DIVP && div_done);
	assign div_in    = div_go_q ? sum_p : sum_r;

	// Pitch divide starts in the cycle after the last scan beat, once the sum is complete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_go_q <= 1'b0;
		end else begin
			div_go_q <= state_q == ST_SCAN && last_j && last_cand;
		end
	end

	wmmp_chan u_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_addr (wp_use),
		.wr_data (s_axis_tdata[31:0]),
		.rd_addr (rd_addr),
		.ctl     (ctl),
		.mid     (mid),
		.even    (even),
		.sum     (sum_p),
		.median  (med_p)
	);

	wmmp_chan u_roll (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_addr (wp_use),
		.wr_data (s_axis_tdata[63:32]),
		.rd_addr (rd_addr),
		.ctl     (ctl),
		.mid     (mid),
		.even    (even),
		.sum     (sum_r),
		.median  (med_r)
	);

	wmmp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_in),
		.divisor  (held_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// Window length, pointer and held count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= wmmp_pkg::LEN_RESET;
			wp_q   <= '0;
			held_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			len_q  <= cfg_data;
			wp_q   <= '0;
			held_q <= '0;
		end else if (in_acc) begin
			if (push) begin
				wp_q <= (wp_inc >= eff_len) ? '0 : wp_inc[wmmp_pkg::IDX_W-1:0];
				if (held_q < eff_len) begin
					held_q <= held_q + 1'b1;
				end
			end else begin
				wp_q   <= '0;
				held_q <= '0;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cand_q  <= '0;
			j_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cand_q  <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					j_q     <= '0;
					state_q <= (held_q == '0) ? ST_FIN : ST_SCAN;
				end
				ST_SCAN: begin
					j_q <= j_q + 1'b1;
					if (last_j) begin
						if (last_cand) begin
							state_q <= ST_DIVP;
						end else begin
							cand_q  <= cand_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_DIVP: begin
					if (div_done) begin
						state_q <= ST_DIVR;
					end
				end
				ST_DIVR: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Mean capture
	always_ff @(posedge clk) begin
		if (state_q == ST_DIVP && div_done) begin
			mean_p_q <= div_q;
		end
		if (state_q == ST_DIVR && div_done) begin
			mean_r_q <= div_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			if (held_q == '0) begin
				out_data_q <= '0;
				out_user_q <= 1'b0;
			end else begin
				out_data_q <= {3'b000, held_q, med_r, med_p, mean_r_q, mean_p_q};
				out_user_q <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_user_q;

`ifndef NO_ASSERTIONS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= eff_len)
		else $error("held count above window length");

	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> ({1'b0, wp_q} < eff_len))
		else $error("write pointer outside window");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIVP || state_q == ST_DIVR))
		else $error("divider finished outside a divide step");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[132:128] != '0) == m_axis_tuser[0]))
		else $error("stats_valid disagrees with sample count");
`endif

endmodule
